// ===== rtl/bspm_pkg.sv =====
// Shared constants and types for the byte stream pattern matcher.
`default_nettype none
package bspm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int PAT_BYTES   = 16;
    localparam int WIN_DEPTH   = 2 * MAX_PATTERN - 1;
    localparam int CW_DEPTH    = 2 * MAX_PATTERN;
    localparam int IDX_BITS    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
    localparam int FILL_BITS   = $clog2(CW_DEPTH + 1);
    localparam int CNT_BITS    = 32;
    localparam int HOFF_BITS   = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    localparam logic [2:0] CFG_PAT_LO  = 3'd0;
    localparam logic [2:0] CFG_PAT_HI  = 3'd1;
    localparam logic [2:0] CFG_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_WIDE_EN = 3'd3;
    localparam logic [2:0] CFG_FILTER  = 3'd4;

    localparam logic [2:0] FILTER_ALL = 3'd4;

    localparam logic HIT_ASCII = 1'b0;
    localparam logic HIT_WIDE  = 1'b1;

    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [4:0]             length;
        logic                   wide_en;
        logic [2:0]             filter;
    } t_cfg;

    typedef struct packed {
        logic                 kind;
        logic [HOFF_BITS-1:0] offset;
        logic [CNT_BITS-1:0]  total;
        logic                 last;
    } t_hit;

    typedef struct packed {
        logic [1:0] n;
        t_hit       e0;
        t_hit       e1;
    } t_push;

endpackage
`default_nettype wire

// ===== rtl/bspm_scan.sv =====
// Input register, byte window, parallel compare and region state.
`default_nettype none
module bspm_scan (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bspm_pkg::t_cfg        i_cfg,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic [1:0]            i_region_type,
    input  wire logic                  i_region_first,
    input  wire logic                  i_room,
    output bspm_pkg::t_push            o_push
);

    logic                               r_in_valid;
    logic [7:0]                         r_byte;
    logic [1:0]                         r_type;
    logic                               r_first;
    logic [7:0]                         r_win [bspm_pkg::WIN_DEPTH];
    logic [bspm_pkg::FILL_BITS-1:0]     r_fill;
    logic [bspm_pkg::OFFSET_BITS-1:0]   r_pos;
    logic [bspm_pkg::CNT_BITS-1:0]      r_cnt;
    logic [bspm_pkg::MAX_PATTERN-1:0]   r_hist;

    logic                               accept;
    logic                               commit;
    logic [7:0]                         cw [bspm_pkg::CW_DEPTH];
    logic [7:0]                         pat [bspm_pkg::MAX_PATTERN];
    logic [bspm_pkg::LEN_BITS-1:0]      len;
    logic [bspm_pkg::LEN_BITS-1:0]      lm1;
    logic [bspm_pkg::LEN_BITS:0]        len2;
    logic [bspm_pkg::OFFSET_BITS-1:0]   cur;
    logic [bspm_pkg::OFFSET_BITS-1:0]   off_a;
    logic [bspm_pkg::OFFSET_BITS-1:0]   off_w;
    logic [bspm_pkg::FILL_BITS-1:0]     n_fill;
    logic [bspm_pkg::MAX_PATTERN-1:0]   hist_rd;
    logic [bspm_pkg::MAX_PATTERN-1:0]   a_ok;
    logic [bspm_pkg::MAX_PATTERN-1:0]   w_ok;
    logic                               ascii;
    logic                               wide;
    logic                               pass;
    logic [bspm_pkg::CNT_BITS-1:0]      base;
    logic [bspm_pkg::CNT_BITS-1:0]      tot1;
    logic [bspm_pkg::CNT_BITS-1:0]      tot2;
    logic [bspm_pkg::CNT_BITS-1:0]      n_cnt;
    bspm_pkg::t_hit                     hit_a;
    bspm_pkg::t_hit                     hit_w;

    function automatic logic [bspm_pkg::CNT_BITS-1:0] sat_inc(
        input logic [bspm_pkg::CNT_BITS-1:0] v
    );
        return (&v) ? v : v + 1'b1;
    endfunction

    assign o_in_stall = r_in_valid && !i_room;
    assign accept     = i_in_valid && !o_in_stall;
    assign commit     = r_in_valid && i_room;

    always_comb begin
        cw[0] = r_byte;
        for (int k = 1; k < bspm_pkg::CW_DEPTH; k++) begin
            cw[k] = r_win[k-1];
        end
        for (int i = 0; i < bspm_pkg::MAX_PATTERN; i++) begin
            if (i < bspm_pkg::PAT_BYTES) begin
                pat[i] = i_cfg.pattern[8*i +: 8];
            end else begin
                pat[i] = 8'h00;
            end
        end
    end

    // Clamp the configured length to the maximum pattern length.
    always_comb begin
        if (int'(i_cfg.length) > bspm_pkg::MAX_PATTERN) begin
            len = bspm_pkg::LEN_BITS'(bspm_pkg::MAX_PATTERN);
        end else begin
            len = bspm_pkg::LEN_BITS'(i_cfg.length);
        end
        lm1  = len - 1'b1;
        len2 = {len, 1'b0};
    end

    always_comb begin
        cur     = r_first ? '0 : r_pos;
        hist_rd = r_first ? '0 : r_hist;
        base    = r_first ? '0 : r_cnt;
        if (r_first) begin
            n_fill = bspm_pkg::FILL_BITS'(1);
        end else if (int'(r_fill) >= bspm_pkg::CW_DEPTH) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + 1'b1;
        end
    end

    // Pattern byte i lines up with window byte len-1-i; the wide form pairs it
    // with the byte pair at twice that distance.
    always_comb begin
        logic [bspm_pkg::LEN_BITS-1:0] jj;
        for (int i = 0; i < bspm_pkg::MAX_PATTERN; i++) begin
            jj = lm1 - bspm_pkg::LEN_BITS'(i);
            if (bspm_pkg::LEN_BITS'(i) < len) begin
                a_ok[i] = (cw[{1'b0, jj[bspm_pkg::IDX_BITS-1:0]}] == pat[i]);
                w_ok[i] = (cw[{jj[bspm_pkg::IDX_BITS-1:0], 1'b1}] == pat[i]) &&
                          (cw[{jj[bspm_pkg::IDX_BITS-1:0], 1'b0}] == 8'h00);
            end else begin
                a_ok[i] = 1'b1;
                w_ok[i] = 1'b1;
            end
        end
    end

    always_comb begin
        ascii = (len != '0) && ({1'b0, n_fill} >= (bspm_pkg::FILL_BITS+1)'(len)) && (&a_ok);
        wide  = (len != '0) && i_cfg.wide_en &&
                ({1'b0, n_fill} >= (bspm_pkg::FILL_BITS+1)'(len2)) &&
                !hist_rd[lm1[bspm_pkg::IDX_BITS-1:0]] && (&w_ok);
        pass  = (i_cfg.filter == bspm_pkg::FILTER_ALL) || (i_cfg.filter == {1'b0, r_type});
        off_a = cur - bspm_pkg::OFFSET_BITS'(len) + 1'b1;
        off_w = cur - bspm_pkg::OFFSET_BITS'(len2) + 1'b1;
        tot1  = sat_inc(base);
        tot2  = sat_inc(tot1);
    end

    always_comb begin
        hit_w.kind   = bspm_pkg::HIT_WIDE;
        hit_w.offset = bspm_pkg::HOFF_BITS'(off_w);
        hit_w.total  = tot1;
        hit_w.last   = !ascii;
        hit_a.kind   = bspm_pkg::HIT_ASCII;
        hit_a.offset = bspm_pkg::HOFF_BITS'(off_a);
        hit_a.total  = wide ? tot2 : tot1;
        hit_a.last   = 1'b1;

        o_push.e0 = wide ? hit_w : hit_a;
        o_push.e1 = hit_a;
        if (!commit || !pass) begin
            o_push.n = 2'd0;
        end else begin
            o_push.n = {1'b0, ascii} + {1'b0, wide};
        end

        case (o_push.n)
            2'd1:    n_cnt = tot1;
            2'd2:    n_cnt = tot2;
            default: n_cnt = base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fill     <= '0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_hist     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (commit) begin
                r_in_valid <= 1'b0;
            end
            if (commit) begin
                r_fill <= n_fill;
                r_pos  <= cur + 1'b1;
                r_cnt  <= n_cnt;
                r_hist <= {hist_rd[bspm_pkg::MAX_PATTERN-2:0], ascii};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bspm_pkg::WIN_DEPTH; k++) begin
                r_win[k] <= 8'h00;
            end
        end else if (commit) begin
            r_win[0] <= r_byte;
            for (int k = 1; k < bspm_pkg::WIN_DEPTH; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte  <= i_data_byte;
            r_type  <= i_region_type;
            r_first <= i_region_first;
        end
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.n == 2'd2 |-> o_push.e0.kind == bspm_pkg::HIT_WIDE &&
                             o_push.e1.kind == bspm_pkg::HIT_ASCII &&
                             !o_push.e0.last && o_push.e1.last)
        else $error("two hits from one word out of order");

    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_hist[0] == $past(ascii))
        else $error("ascii match not recorded in history");

endmodule
`default_nettype wire

// ===== rtl/bspm_hit_fifo.sv =====
// Small result queue that takes up to two hits per cycle and gives one per cycle unless its output is stalled.
`default_nettype none
module bspm_hit_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bspm_pkg::t_push    i_push,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output bspm_pkg::t_hit          o_hit
);

    bspm_pkg::t_hit                   r_mem [bspm_pkg::QDEPTH];
    logic [bspm_pkg::QPTR_BITS-1:0]   r_wr;
    logic [bspm_pkg::QPTR_BITS-1:0]   r_rd;
    logic [bspm_pkg::QCNT_BITS-1:0]   r_count;
    logic [bspm_pkg::QPTR_BITS-1:0]   wr1;
    logic                             pop;

    assign o_valid = (r_count != '0);
    assign o_hit   = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign wr1     = r_wr + 1'b1;
    // Room for the worst case of two hits from one word.
    assign o_room  = (int'(r_count) <= bspm_pkg::QDEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + i_push.n;
            r_rd    <= r_rd + {{(bspm_pkg::QPTR_BITS-1){1'b0}}, pop};
            r_count <= r_count + bspm_pkg::QCNT_BITS'(i_push.n)
                     - {{(bspm_pkg::QCNT_BITS-1){1'b0}}, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr1] <= i_push.e1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n != 2'd0 |-> int'(r_count) + int'(i_push.n) <= bspm_pkg::QDEPTH)
        else $error("hit queue overflow");

endmodule
`default_nettype wire

// ===== rtl/byte_stream_pattern_matcher.sv =====
// Top level: configuration registers, scan stage and hit queue.
// Takes one region byte per cycle unless stalled and reports matches of a
// pattern of up to 16 bytes ending on that byte in regions that pass the type
// filter, as an exact byte match and, when enabled, as its UTF-16LE form (each
// pattern byte followed by a zero byte). The scan stage holds a 31-byte window
// plus the word in its input register and compares all pattern positions in
// parallel. A hit passes through the input register and a four-entry queue
// before it leaves the output; a word that completes two hits fills two entries.
// The input stalls only while the queue has under two free entries, so one word
// per cycle holds while the output is not stalled and hits average at most one.
// Configuration must be written only while no word is in flight (not enforced).
`default_nettype none
module byte_stream_pattern_matcher (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic [1:0]   i_region_type,
    input  wire logic         i_region_first,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic              o_hit_kind,
    output logic [31:0]       o_hit_offset,
    output logic [31:0]       o_hit_total,
    output logic              o_last_of_run
);

    logic [63:0]          r_pat_lo;
    logic [63:0]          r_pat_hi;
    logic [4:0]           r_length;
    logic                 r_wide_en;
    logic [2:0]           r_filter;
    bspm_pkg::t_cfg       cfg;
    bspm_pkg::t_push      push;
    bspm_pkg::t_hit       hit;
    logic                 room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_length  <= 5'd1;
            r_wide_en <= 1'b0;
            r_filter  <= bspm_pkg::FILTER_ALL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bspm_pkg::CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                bspm_pkg::CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                bspm_pkg::CFG_LENGTH:  r_length  <= i_cfg_data[4:0];
                bspm_pkg::CFG_WIDE_EN: r_wide_en <= i_cfg_data[0];
                bspm_pkg::CFG_FILTER:  r_filter  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern = {r_pat_hi, r_pat_lo};
    assign cfg.length  = r_length;
    assign cfg.wide_en = r_wide_en;
    assign cfg.filter  = r_filter;

    bspm_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_region_type  (i_region_type),
        .i_region_first (i_region_first),
        .i_room         (room),
        .o_push         (push)
    );

    bspm_hit_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_hit   (hit)
    );

    assign o_hit_kind    = hit.kind;
    assign o_hit_offset  = hit.offset;
    assign o_hit_total   = hit.total;
    assign o_last_of_run = hit.last;

endmodule
`default_nettype wire
